// File: design/mnp_pkg.sv
package mnp_pkg;

    // Fixed sizes of the message and result fields.
    localparam int KEY_COUNT         = 128;
    localparam int KEY_BITS          = $clog2(KEY_COUNT);
    localparam int FIELD_BITS        = 32;
    localparam int TICK_BITS_DEFAULT = 32;

    // Command decode of the status byte; the channel nibble is masked off.
    localparam logic [7:0] CMD_MASK     = 8'hF0;
    localparam logic [7:0] CMD_NOTE_ON  = 8'h90;
    localparam logic [7:0] CMD_NOTE_OFF = 8'h80;

    // One MIDI channel message.
    typedef struct packed {
        logic [7:0]            status_byte;
        logic [KEY_BITS-1:0]   key_number;
        logic [6:0]            key_velocity;
        logic [FIELD_BITS-1:0] event_tick;
    } in_item_t;

    // One closed note.
    typedef struct packed {
        logic [FIELD_BITS-1:0] note_start;
        logic [FIELD_BITS-1:0] note_length;
        logic [KEY_BITS-1:0]   note_key;
    } out_item_t;

    // Read and write control of the start-tick table.
    typedef struct packed {
        logic                rd_en;
        logic [KEY_BITS-1:0] rd_key;
        logic                wr_en;
        logic [KEY_BITS-1:0] wr_key;
    } table_ctl_t;

endpackage

// File: design/mnp_start_table.sv
module mnp_start_table #(
    parameter int DATA_BITS = mnp_pkg::FIELD_BITS
) (
    input  logic                   aclk,
    input  mnp_pkg::table_ctl_t    ctl,
    input  logic [DATA_BITS-1:0]   wr_data,
    output logic [DATA_BITS-1:0]   rd_data
);

    logic [DATA_BITS-1:0] mem [mnp_pkg::KEY_COUNT];
    logic [DATA_BITS-1:0] rd_data_reg;

    // Write port; an entry holds the start tick of the last note-on for its pitch.
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[ctl.wr_key] <= wr_data;
        end
    end

    // Registered read port. A read in the same cycle as a write returns the old data.
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data_reg <= mem[ctl.rd_key];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/mnp_pair_stage.sv
module mnp_pair_stage #(
    parameter int TICK_BITS = mnp_pkg::TICK_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mnp_pkg::in_item_t   s_item,
    input  logic                out_free,
    output logic                res_load,
    output mnp_pkg::out_item_t  res_item
);

    localparam int FB = mnp_pkg::FIELD_BITS;
    localparam int SB = (TICK_BITS < FB) ? TICK_BITS : FB;

    logic                              stage_valid_reg;
    mnp_pkg::in_item_t                 stage_item_reg;
    logic                              hit_reg;
    logic [SB-1:0]                     fwd_tick_reg;
    logic [mnp_pkg::KEY_COUNT-1:0]     open_valid_reg;

    logic                              is_on;
    logic                              is_off;
    logic                              opens;
    logic                              emits;
    logic                              go;
    logic                              accept;
    logic [SB-1:0]                     tick_cur;
    logic [SB-1:0]                     start_cur;
    logic [SB-1:0]                     length_cur;
    logic [SB-1:0]                     rd_data;
    mnp_pkg::table_ctl_t               ctl;

    // Decode the message held in the stage register.
    always_comb begin
        is_on  = (stage_item_reg.status_byte & mnp_pkg::CMD_MASK) == mnp_pkg::CMD_NOTE_ON;
        is_off = (stage_item_reg.status_byte & mnp_pkg::CMD_MASK) == mnp_pkg::CMD_NOTE_OFF;
        opens  = is_on && (stage_item_reg.key_velocity != 7'd0);
        emits  = (is_on || is_off) && !opens && open_valid_reg[stage_item_reg.key_number];
    end

    // The stage moves on unless it holds a result and the result register is full and not being taken.
    assign go      = stage_valid_reg && (!emits || out_free);
    assign s_ready = !stage_valid_reg || go;
    assign accept  = s_valid && s_ready;

    // Table access: read at acceptance, write when a note-on with nonzero velocity leaves the stage.
    always_comb begin
        ctl.rd_en  = accept;
        ctl.rd_key = s_item.key_number;
        ctl.wr_en  = go && opens;
        ctl.wr_key = stage_item_reg.key_number;
    end

    mnp_start_table #(
        .DATA_BITS (SB)
    ) u_start_table (
        .aclk    (aclk),
        .ctl     (ctl),
        .wr_data (tick_cur),
        .rd_data (rd_data)
    );

    // Start tick, with the note-on that wrote the table in the read cycle forwarded.
    always_comb begin
        tick_cur   = stage_item_reg.event_tick[SB-1:0];
        start_cur  = hit_reg ? fwd_tick_reg : rd_data;
        length_cur = tick_cur - start_cur;
    end

    always_comb begin
        res_load             = go && emits;
        res_item.note_start  = FB'(start_cur);
        res_item.note_length = FB'(length_cur);
        res_item.note_key    = stage_item_reg.key_number;
    end

    // Stage register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (accept) begin
            stage_valid_reg <= 1'b1;
        end else if (go) begin
            stage_valid_reg <= 1'b0;
        end
    end

    // Stage payload and forwarding data.
    always_ff @(posedge aclk) begin
        if (accept) begin
            stage_item_reg <= s_item;
            hit_reg        <= go && opens && (stage_item_reg.key_number == s_item.key_number);
            fwd_tick_reg   <= tick_cur;
        end
    end

    // Open-note marks: set by a note-on with nonzero velocity, cleared when a note closes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_valid_reg <= '0;
        end else if (go && opens) begin
            open_valid_reg[stage_item_reg.key_number] <= 1'b1;
        end else if (go && emits) begin
            open_valid_reg[stage_item_reg.key_number] <= 1'b0;
        end
    end

endmodule

// File: design/midi_note_pairing_unit.sv
// Channel  Direction  Handshake          Payload
// s_       in         s_valid / s_ready  s_item  : status, key, velocity, tick
// m_       out        m_valid / m_ready  m_item  : start, length, key
//
// One message is taken every cycle while the input is not stalled. A closing
// message and its table read are registered together in the stage, and the
// result register is loaded from the stage; the closed note then appears on m_.
// Reset clears all open-note marks together, with no sweep.
// A closing message waits in the stage while the result register is full and
// not being taken, and the input stalls behind it; other messages never wait.
module midi_note_pairing_unit #(
    parameter int TICK_BITS = mnp_pkg::TICK_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mnp_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output mnp_pkg::out_item_t  m_item
);

    logic               m_valid_reg;
    mnp_pkg::out_item_t m_item_reg;
    logic               out_free;
    logic               res_load;
    mnp_pkg::out_item_t res_item;

    assign out_free = !m_valid_reg || m_ready;

    mnp_pair_stage #(
        .TICK_BITS (TICK_BITS)
    ) u_pair_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .out_free (out_free),
        .res_load (res_load),
        .res_item (res_item)
    );

    // Result register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_item_reg <= res_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// File: design/mnp_checker.sv
module mnp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input mnp_pkg::in_item_t   s_item,
    input logic                m_valid,
    input logic                m_ready,
    input mnp_pkg::out_item_t  m_item
);

    // A result waiting to be taken holds still.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // With the result register empty nothing can block the input.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked while result register empty");

    // No result right after reset.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A note-on directly followed by its note-off gives that note once the result register is free.
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready
            && ((s_item.status_byte & mnp_pkg::CMD_MASK) == mnp_pkg::CMD_NOTE_ON)
            && (s_item.key_velocity != 7'd0))
        ##1 (s_valid && s_ready && (s_item.key_number == $past(s_item.key_number))
            && (((s_item.status_byte & mnp_pkg::CMD_MASK) == mnp_pkg::CMD_NOTE_OFF)
                || (((s_item.status_byte & mnp_pkg::CMD_MASK) == mnp_pkg::CMD_NOTE_ON)
                    && (s_item.key_velocity == 7'd0))))
        ##1 (!m_valid || m_ready)
        |=> m_valid && (m_item.note_key == $past(s_item.key_number, 2))
            && (m_item.note_start[15:0] == $past(s_item.event_tick[15:0], 3))
            && (m_item.note_length[15:0] == ($past(s_item.event_tick[15:0], 2)
                - $past(s_item.event_tick[15:0], 3))))
        else $error("note-on and note-off pair gave a wrong result");

endmodule

bind midi_note_pairing_unit mnp_checker u_mnp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
